FILE: rtl/core/overwriting_log_ring_buffer_macros.svh
// Assertion macros for the overwriting log ring buffer checks.
`ifndef OVERWRITING_LOG_RING_BUFFER_MACROS_SVH
`define OVERWRITING_LOG_RING_BUFFER_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define OLRB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define OLRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/olrb_pkg.sv
// Shared types and constants of the overwriting log ring buffer.
package olrb_pkg;

    localparam int BYTE_W = 8;
    localparam int RUN_W  = 7;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic              is_read;
        logic [BYTE_W-1:0] data;
        logic [RUN_W-1:0]  run;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic [RUN_W-1:0]  run_length;
        logic              is_last;
        logic              empty_res;
    } t_res;

    typedef enum logic [0:0] {
        BK_IDLE,
        BK_STREAM
    } t_back_state;

endpackage

FILE: rtl/core/olrb_if.sv
// Request and result channel interfaces of the overwriting log ring buffer.
interface olrb_in_if import olrb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [BYTE_W-1:0] data_byte;
    logic [RUN_W-1:0]  request_count;

    modport source (output valid, output command, output data_byte, output request_count,
                    input ready);
    modport sink   (input valid, input command, input data_byte, input request_count,
                    output ready);
endinterface

interface olrb_out_if import olrb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_out;
    logic [RUN_W-1:0]  run_length;
    logic              is_last;
    logic              empty_res;

    modport source (output valid, output byte_out, output run_length, output is_last,
                    output empty_res, input ready);
    modport sink   (input valid, input byte_out, input run_length, input is_last,
                    input empty_res, output ready);
endinterface

FILE: rtl/core/olrb_ram.sv
// Generic simple dual-port RAM with registered read.
module olrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/olrb_front.sv
// Request intake: ring pointer, fill level and read run sizing.
module olrb_front import olrb_pkg::*; #(
    parameter int DEPTH    = 1024,
    parameter int MAX_READ = 64,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    olrb_in_if.sink       i_req,
    input  logic          i_q_full,
    output logic          o_push,
    output t_cmd          o_cmd,
    output logic [PW-1:0] o_addr
);

    localparam int CW = ((PW > RUN_W) ? PW : RUN_W) + 1;

    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    r_held;
    logic [PW-1:0]    n_held;
    logic             accept;
    logic [RUN_W-1:0] run_sat;
    logic [RUN_W-1:0] run;
    logic [CW-1:0]    start_ext;

    assign i_req.ready = !i_q_full;
    assign accept      = i_req.valid & i_req.ready;

    always_comb begin
        run_sat = (i_req.request_count > RUN_W'(MAX_READ)) ? RUN_W'(MAX_READ)
                                                           : i_req.request_count;
        run     = (CW'(run_sat) > CW'(r_held)) ? RUN_W'(r_held) : run_sat;
        start_ext = CW'(r_wr_ptr) - CW'(run);
        if (CW'(r_wr_ptr) < CW'(run)) begin
            start_ext = start_ext + CW'(DEPTH);
        end
    end

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_held   = (r_held == PW'(DEPTH - 1)) ? r_held : r_held + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_held   <= '0;
        end else if (accept && (i_req.command == CMD_WRITE)) begin
            r_wr_ptr <= n_wr_ptr;
            r_held   <= n_held;
        end
    end

    assign o_push        = accept;
    assign o_cmd.is_read = (i_req.command == CMD_READ);
    assign o_cmd.data    = i_req.data_byte;
    assign o_cmd.run     = run;
    assign o_addr        = (i_req.command == CMD_READ) ? start_ext[PW-1:0] : r_wr_ptr;

endmodule

FILE: rtl/core/olrb_cmd_fifo.sv
// Two-entry command queue between intake and execution.
module olrb_cmd_fifo #(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    logic [WIDTH-1:0] r_slot [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             do_pop;

    assign do_pop  = i_pop & (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: rtl/core/olrb_back.sv
// Command execution: log store writes and read run streaming with output skid.
module olrb_back import olrb_pkg::*; #(
    parameter int DEPTH = 1024,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_cmd              i_cmd,
    input  logic [PW-1:0]     i_addr,
    output logic              o_pop,
    output logic              o_wr_en,
    output logic [PW-1:0]     o_wr_addr,
    output logic [BYTE_W-1:0] o_wr_data,
    output logic              o_rd_en,
    output logic [PW-1:0]     o_rd_addr,
    input  logic [BYTE_W-1:0] i_rd_data,
    olrb_out_if.source        o_res
);

    t_back_state      r_state;
    t_back_state      n_state;
    logic [PW-1:0]    r_addr;
    logic [RUN_W-1:0] r_left;
    logic [RUN_W-1:0] r_len;
    logic             r_fl_v;
    logic             r_fl_empty;
    logic             r_fl_last;
    logic [RUN_W-1:0] r_fl_len;
    logic             r_out_v;
    t_res             r_out;
    logic             r_sk_v;
    t_res             r_sk;

    logic             pop_out;
    logic [1:0]       load;
    logic             can_issue;
    logic             issue;
    logic             issue_empty;
    logic             issue_last;
    logic [RUN_W-1:0] issue_len;
    logic             start_run;
    logic             step_run;
    t_res             inc;

    assign pop_out   = r_out_v & o_res.ready;
    assign load      = {1'b0, r_out_v} + {1'b0, r_sk_v} + {1'b0, r_fl_v};
    assign can_issue = ((load - {1'b0, pop_out}) < 2'd2);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid && i_cmd.is_read && (i_cmd.run != '0)) begin
                    n_state = BK_STREAM;
                end
            end
            BK_STREAM: begin
                if (can_issue && (r_left == RUN_W'(1))) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        o_wr_en     = 1'b0;
        o_rd_en     = 1'b0;
        issue       = 1'b0;
        issue_empty = 1'b0;
        issue_last  = 1'b0;
        issue_len   = '0;
        start_run   = 1'b0;
        step_run    = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    if (!i_cmd.is_read) begin
                        o_pop   = 1'b1;
                        o_wr_en = 1'b1;
                    end else if (i_cmd.run == '0) begin
                        if (can_issue) begin
                            o_pop       = 1'b1;
                            issue       = 1'b1;
                            issue_empty = 1'b1;
                            issue_last  = 1'b1;
                        end
                    end else begin
                        o_pop     = 1'b1;
                        start_run = 1'b1;
                    end
                end
            end
            BK_STREAM: begin
                if (can_issue) begin
                    o_rd_en    = 1'b1;
                    issue      = 1'b1;
                    step_run   = 1'b1;
                    issue_len  = r_len;
                    issue_last = (r_left == RUN_W'(1));
                end
            end
            default: ;
        endcase
    end

    assign o_wr_addr = i_addr;
    assign o_wr_data = i_cmd.data;
    assign o_rd_addr = r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_run) begin
            r_addr <= i_addr;
            r_left <= i_cmd.run;
            r_len  <= i_cmd.run;
        end else if (step_run) begin
            r_addr <= (r_addr == PW'(DEPTH - 1)) ? '0 : r_addr + 1'b1;
            r_left <= r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fl_v <= 1'b0;
        end else begin
            r_fl_v <= issue;
        end
        r_fl_empty <= issue_empty;
        r_fl_last  <= issue_last;
        r_fl_len   <= issue_len;
    end

    always_comb begin
        inc.byte_out   = r_fl_empty ? '0 : i_rd_data;
        inc.run_length = r_fl_len;
        inc.is_last    = r_fl_last;
        inc.empty_res  = r_fl_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (!r_out_v || pop_out) begin
            if (r_sk_v) begin
                r_out_v <= 1'b1;
                r_out   <= r_sk;
                r_sk_v  <= r_fl_v;
                r_sk    <= inc;
            end else begin
                r_out_v <= r_fl_v;
                r_out   <= inc;
            end
        end else if (r_fl_v) begin
            r_sk_v <= 1'b1;
            r_sk   <= inc;
        end
    end

    assign o_res.valid      = r_out_v;
    assign o_res.byte_out   = r_out.byte_out;
    assign o_res.run_length = r_out.run_length;
    assign o_res.is_last    = r_out.is_last;
    assign o_res.empty_res  = r_out.empty_res;

endmodule

FILE: rtl/core/overwriting_log_ring_buffer.sv
// Top level of the overwriting log ring buffer.
// Write request: taken every cycle while the command queue has room, one log store write per cycle
// while the executor is idle. Read request: dequeued, then one result per cycle while the output has
// room; a byte passes the run address, log store read and output registers, an empty result the
// flight and output registers. A read of N bytes holds the executor until its N reads are issued.
// Synchronous active-low reset empties the log and queue; log store contents are not cleared.
module overwriting_log_ring_buffer import olrb_pkg::*; #(
    parameter int DEPTH    = 1024,
    parameter int MAX_READ = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    olrb_in_if.sink    i_req,
    olrb_out_if.source o_res
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW = $bits(t_cmd) + PW;

    logic              q_full;
    logic              q_push;
    logic              q_valid;
    logic              q_pop;
    t_cmd              front_cmd;
    logic [PW-1:0]     front_addr;
    logic [QW-1:0]     q_data;
    t_cmd              back_cmd;
    logic [PW-1:0]     back_addr;
    logic              wr_en;
    logic [PW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [PW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;

    olrb_front #(
        .DEPTH   (DEPTH),
        .MAX_READ(MAX_READ)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_q_full(q_full),
        .o_push  (q_push),
        .o_cmd   (front_cmd),
        .o_addr  (front_addr)
    );

    olrb_cmd_fifo #(
        .WIDTH(QW)
    ) u_cmd_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data ({front_cmd, front_addr}),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_data (q_data),
        .i_pop  (q_pop)
    );

    assign {back_cmd, back_addr} = q_data;

    olrb_back #(
        .DEPTH(DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_cmd    (back_cmd),
        .i_addr   (back_addr),
        .o_pop    (q_pop),
        .o_wr_en  (wr_en),
        .o_wr_addr(wr_addr),
        .o_wr_data(wr_data),
        .o_rd_en  (rd_en),
        .o_rd_addr(rd_addr),
        .i_rd_data(rd_data),
        .o_res    (o_res)
    );

    olrb_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(DEPTH)
    ) u_log_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

endmodule

FILE: rtl/core/olrb_checker.sv
// Port-level checks of the overwriting log ring buffer and their binding.
`include "overwriting_log_ring_buffer_macros.svh"

module olrb_checker import olrb_pkg::*; #(
    parameter int MAX_READ = 64
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input logic [BYTE_W-1:0] i_byte_out,
    input logic [RUN_W-1:0]  i_run_length,
    input logic              i_is_last,
    input logic              i_empty_res
);

    `OLRB_ASSERT_NOW(a_empty_shape, i_res_valid && i_empty_res, i_is_last && (i_run_length == '0) && (i_byte_out == '0), "empty result malformed")

    `OLRB_ASSERT_NOW(a_run_bounds, i_res_valid && !i_empty_res, (i_run_length != '0) && (i_run_length <= RUN_W'(MAX_READ)), "run length out of range")

    `OLRB_ASSERT_NEXT(a_run_steady, i_res_valid && i_res_ready && !i_is_last, !i_res_valid || (i_run_length == $past(i_run_length)), "run length changed inside a run")

    `OLRB_ASSERT_NEXT(a_hold_stall, i_res_valid && !i_res_ready, i_res_valid && $stable(i_byte_out) && $stable(i_run_length) && $stable(i_is_last) && $stable(i_empty_res), "stalled result changed")

endmodule

bind overwriting_log_ring_buffer olrb_checker #(
    .MAX_READ(MAX_READ)
) u_olrb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_byte_out  (o_res.byte_out),
    .i_run_length(o_res.run_length),
    .i_is_last   (o_res.is_last),
    .i_empty_res (o_res.empty_res)
);
